// ----- rtl/sparse_time_index_floor_search_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sparse time index floor search
// Wrap concurrent checks that sample on clk and stay off during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TIME_INDEX_FLOOR_SEARCH_MACROS_SVH
`define SPARSE_TIME_INDEX_FLOOR_SEARCH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STIFS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STIFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/stifs_pkg.sv -----
// ----------------------------------------------------------------------------
// stifs_pkg
// Shared widths, register indexes and result kinds of the time index search.
// ----------------------------------------------------------------------------
package stifs_pkg;

  localparam int unsigned DEPTH_DEF  = 256;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLDEST_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWEST_TIME   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OLDEST_RECORD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWEST_RECORD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECS_PER_BLK  = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEFORE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AFTER   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXACT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EARLIER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

  // Item function
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- rtl/sparse_time_index_floor_search.sv -----
// ----------------------------------------------------------------------------
// sparse_time_index_floor_search
// Sorted (timestamp, block) index in one synchronous memory with a floor
// lookup by binary search and a serial divider for out-of-range queries.
// ----------------------------------------------------------------------------
//  channel  direction  fields (tdata / tuser, lowest bit first)
//  in_      slave      tdata: entry_slot, entry_time, entry_block, query_time
//                      tuser: func (0 write entry, 1 query)
//  out_     master     tdata: blk_num   tuser: result_kind
//  cfg_     write      cfg_index selects register, cfg_wdata value
//
//  A write item is taken in the idle state and gives no result. A query
//  does each table probe as a memory read, then a compare; a boundary query
//  runs the 32-step serial divider instead. One item is in work at a time;
//  a finished result waits for the output register, and in_tready stays low.
//  Reset is synchronous, active low, and leaves the table contents as they are.
// ----------------------------------------------------------------------------
`include "sparse_time_index_floor_search_macros.svh"

module sparse_time_index_floor_search
  import stifs_pkg::*;
#(
  parameter int unsigned INDEX_DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: entry_slot[7:0], entry_time[39:8], entry_block[71:40],
  //           query_time[103:72]
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [103:0]         in_tdata,
  input  logic                 in_tuser,   // func
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_W-1:0]    out_tdata,  // blk_num
  output logic [KIND_W-1:0]    out_tuser,  // result_kind
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  localparam int unsigned AW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(INDEX_DEPTH + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned NSLOT = 1 << SLOT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // input fields
  logic [SLOT_W-1:0] in_slot;
  word_t             in_entry_time;
  word_t             in_entry_block;
  word_t             in_query_time;
  logic              in_fire;

  assign in_slot        = in_tdata[7:0];
  assign in_entry_time  = in_tdata[39:8];
  assign in_entry_block = in_tdata[71:40];
  assign in_query_time  = in_tdata[103:72];

  // configuration
  logic [COUNT_W-1:0] entry_count_r;
  word_t oldest_time_r, newest_time_r, oldest_record_r, newest_record_r;
  word_t recs_per_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      oldest_time_r   <= '0;
      newest_time_r   <= '0;
      oldest_record_r <= '0;
      newest_record_r <= '0;
      recs_per_blk_r  <= word_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY_COUNT:   entry_count_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_OLDEST_TIME:   oldest_time_r   <= cfg_wdata;
        CFG_NEWEST_TIME:   newest_time_r   <= cfg_wdata;
        CFG_OLDEST_RECORD: oldest_record_r <= cfg_wdata;
        CFG_NEWEST_RECORD: newest_record_r <= cfg_wdata;
        CFG_RECS_PER_BLK:  recs_per_blk_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the searched count to the table depth
  logic [XW-1:0] ec_x;
  logic [CW-1:0] count;

  assign ec_x  = XW'(entry_count_r);
  assign count = (ec_x > XW'(INDEX_DEPTH)) ? CW'(INDEX_DEPTH) : CW'(ec_x);

  // slot wrap table: slot modulo depth, folded at elaboration
  logic [AW-1:0] wrap_tbl [NSLOT];

  for (genvar g = 0; g < NSLOT; g++) begin : g_wrap
    assign wrap_tbl[g] = AW'(g % INDEX_DEPTH);
  end

  // index memory: {block, time} per entry
  logic [2*WORD_W-1:0] mem [INDEX_DEPTH];
  logic [2*WORD_W-1:0] mem_rdata_r;
  logic                mem_we;
  logic [AW-1:0]       mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wrap_tbl[in_slot]] <= {in_entry_block, in_entry_time};
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // control and datapath registers
  logic [2:0]           state_r, state_nxt;
  word_t                q_r, q_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        end_r, end_nxt;
  word_t                best_r, best_nxt;
  logic                 found_r, found_nxt;
  word_t                res_block_r, res_block_nxt;
  logic [KIND_W-1:0]    res_kind_r, res_kind_nxt;
  word_t                div_rem_r, div_rem_nxt;
  word_t                div_quo_r, div_quo_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  word_t                out_block_r, out_block_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  word_t                probe_time;
  word_t                probe_block;
  logic [WORD_W:0]      div_trial;
  logic                 div_bit;
  word_t                div_quo_step;
  logic                 out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // probe the middle of [lo, end)
  assign mid_sum   = {1'b0, lo_r} + {1'b0, end_r} - (CW + 1)'(1);
  assign mid       = mid_sum[CW:1];
  assign mem_raddr = mid[AW-1:0];

  assign probe_time  = mem_rdata_r[WORD_W-1:0];
  assign probe_block = mem_rdata_r[2*WORD_W-1:WORD_W];

  // one restoring division step, dividend shifts out of the quotient register
  assign div_trial    = {div_rem_r, div_quo_r[WORD_W-1]};
  assign div_bit      = (div_trial >= {1'b0, recs_per_blk_r});
  assign div_quo_step = {div_quo_r[WORD_W-2:0], div_bit};

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    res_block_nxt = res_block_r;
    res_kind_nxt  = res_kind_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    div_cnt_nxt   = div_cnt_r;
    out_block_nxt = out_block_r;
    out_kind_nxt  = out_kind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == FUNC_WRITE) begin
            mem_we = 1'b1;
          end else begin
            q_nxt       = in_query_time;
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            if (entry_count_r == '0) begin
              res_block_nxt = '0;
              res_kind_nxt  = KIND_EMPTY;
              state_nxt     = ST_OUT;
            end else if (in_query_time < oldest_time_r) begin
              div_quo_nxt  = oldest_record_r;
              res_kind_nxt = KIND_BEFORE;
              state_nxt    = ST_DIV;
            end else if (in_query_time > newest_time_r) begin
              div_quo_nxt  = newest_record_r;
              res_kind_nxt = KIND_AFTER;
              state_nxt    = ST_DIV;
            end else begin
              lo_nxt    = '0;
              end_nxt   = count;
              found_nxt = 1'b0;
              best_nxt  = '0;
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_DIV: begin
        div_rem_nxt = div_bit ? WORD_W'(div_trial - {1'b0, recs_per_blk_r})
                              : div_trial[WORD_W-1:0];
        div_quo_nxt = div_quo_step;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          res_block_nxt = div_quo_step;
          state_nxt     = ST_OUT;
        end
      end
      ST_RD: begin
        if (lo_r < end_r) begin
          state_nxt = ST_CMP;
        end else begin
          res_block_nxt = found_r ? best_r : '0;
          res_kind_nxt  = found_r ? KIND_EARLIER : KIND_NONE;
          state_nxt     = ST_OUT;
        end
      end
      ST_CMP: begin
        state_nxt = ST_RD;
        if (probe_time == '0) begin
          // unused entry: go left
          end_nxt = mid;
        end else if (probe_time == q_r) begin
          res_block_nxt = probe_block;
          res_kind_nxt  = KIND_EXACT;
          state_nxt     = ST_OUT;
        end else if (probe_time < q_r) begin
          best_nxt  = probe_block;
          found_nxt = 1'b1;
          lo_nxt    = mid + CW'(1);
        end else begin
          end_nxt = mid;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_block_nxt = res_block_r;
          out_kind_nxt  = res_kind_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    res_block_r <= res_block_nxt;
    res_kind_r  <= res_kind_nxt;
    div_rem_r   <= div_rem_nxt;
    div_quo_r   <= div_quo_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_block_r <= out_block_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_block_r;
  assign out_tuser  = out_kind_r;

  // checks
  `STIFS_ASSERT_SAME(a_probe_in_range, state_r == ST_CMP, lo_r < end_r, "probe outside window")
  `STIFS_ASSERT_SAME(a_window_bound, state_r == ST_RD || state_r == ST_CMP,
    end_r <= CW'(INDEX_DEPTH), "search window beyond table")
  `STIFS_ASSERT_NEXT(a_query_busy, in_fire && in_tuser == FUNC_QUERY, state_r != ST_IDLE,
    "query did not start")
  `STIFS_ASSERT_NEXT(a_write_no_result, in_fire && in_tuser == FUNC_WRITE && !out_valid_r,
    !out_valid_r, "write produced a result")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for sparse_time_index_floor_search
// Fills the index table and drives write and query items under varying
// idle patterns and register settings. Each query result is checked against
// a floor search run on a local copy of the table and the registers.
// ----------------------------------------------------------------------------
module testbench;
  import stifs_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 50;
  localparam int HOLD_CYCLES   = 300;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;

  typedef struct packed {
    word_t             block;
    logic [KIND_W-1:0] kind;
  } floor_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [103:0]         in_tdata;   // entry_slot, entry_time, entry_block, query_time
  logic                 in_tuser;   // func
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [WORD_W-1:0]    out_tdata;  // blk_num
  logic [KIND_W-1:0]    out_tuser;  // result_kind
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  // local copy of the table and the registers
  word_t              tab_time  [DEPTH_DEF];
  word_t              tab_block [DEPTH_DEF];
  logic [COUNT_W-1:0] reg_count;
  word_t              reg_oldest_time;
  word_t              reg_newest_time;
  word_t              reg_oldest_rec;
  word_t              reg_newest_rec;
  word_t              reg_recs_per_blk;

  floor_result_t pending_lookups[$];
  floor_result_t due_result;
  int            mismatch_count = 0;
  int            in_idle_pct    = 0;
  int            out_idle_pct   = 0;
  int            hold_token     = 0;
  int            hold_seen      = 0;
  int            hold_left      = 0;

  sparse_time_index_floor_search DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic word_t boundary_block(input word_t rec);
    return (reg_recs_per_blk == 0) ? '1 : rec / reg_recs_per_blk;
  endfunction

  function automatic floor_result_t predict_floor(input word_t q);
    floor_result_t r;
    int            lo, hi, mid, span;
    logic          found, hit;
    word_t         best, t;
    span    = (reg_count > DEPTH_DEF) ? DEPTH_DEF : reg_count;
    r.block = '0;
    r.kind  = KIND_NONE;
    if (reg_count == 0) begin
      r.kind = KIND_EMPTY;
    end else if (q < reg_oldest_time) begin
      r.block = boundary_block(reg_oldest_rec);
      r.kind  = KIND_BEFORE;
    end else if (q > reg_newest_time) begin
      r.block = boundary_block(reg_newest_rec);
      r.kind  = KIND_AFTER;
    end else begin
      lo    = 0;
      hi    = span - 1;
      found = 1'b0;
      hit   = 1'b0;
      best  = '0;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        t   = tab_time[mid];
        // an unused entry steers left
        if (t == 0) begin
          hi = mid - 1;
        end else if (t == q) begin
          hit     = 1'b1;
          r.block = tab_block[mid];
          r.kind  = KIND_EXACT;
        end else if (t < q) begin
          best  = tab_block[mid];
          found = 1'b1;
          lo    = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      if (!hit && found) begin
        r.block = best;
        r.kind  = KIND_EARLIER;
      end
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual block %h kind %0d",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        due_result = pending_lookups.pop_front();
        if (out_tdata !== due_result.block) begin
          $display("%0t: blk_num mismatch: expected %h, actual %h",
                   $time, due_result.block, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== due_result.kind) begin
          $display("%0t: result_kind mismatch: expected %0d, actual %0d",
                   $time, due_result.kind, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_item(input logic func, input logic [SLOT_W-1:0] slot,
                           input word_t etime, input word_t eblock, input word_t qtime);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {qtime, eblock, etime, slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (func == FUNC_WRITE) begin
      tab_time[slot]  = etime;
      tab_block[slot] = eblock;
    end else begin
      pending_lookups.push_back(predict_floor(qtime));
    end
  endtask

  task automatic write_entry(input logic [SLOT_W-1:0] slot, input word_t etime,
                             input word_t eblock);
    send_item(FUNC_WRITE, slot, etime, eblock, $urandom);
  endtask

  task automatic query_at(input word_t qtime);
    send_item(FUNC_QUERY, SLOT_W'($urandom), $urandom, $urandom, qtime);
  endtask

  // Hold the sender until every result is back, then let a pending write finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENTRY_COUNT:   reg_count        = value[COUNT_W-1:0];
      CFG_OLDEST_TIME:   reg_oldest_time  = value;
      CFG_NEWEST_TIME:   reg_newest_time  = value;
      CFG_OLDEST_RECORD: reg_oldest_rec   = value;
      CFG_NEWEST_RECORD: reg_newest_rec   = value;
      CFG_RECS_PER_BLK:  reg_recs_per_blk = value;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [COUNT_W-1:0] count, input word_t old_t,
                            input word_t new_t, input word_t old_rec,
                            input word_t new_rec, input word_t per_blk);
    drain_results();
    write_reg(CFG_ENTRY_COUNT, word_t'(count));
    write_reg(CFG_OLDEST_TIME, old_t);
    write_reg(CFG_NEWEST_TIME, new_t);
    write_reg(CFG_OLDEST_RECORD, old_rec);
    write_reg(CFG_NEWEST_RECORD, new_rec);
    write_reg(CFG_RECS_PER_BLK, per_blk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    in_idle_pct  = sender_pct;
    out_idle_pct = receiver_pct;
  endtask

  // Mostly order-keeping writes and queries aimed at table timestamps
  task automatic random_item();
    int                  span, pick, s;
    logic [SLOT_W-1:0]   slot;
    word_t               lo_t, hi_t, tm, t, q;
    span = (reg_count > DEPTH_DEF) ? DEPTH_DEF : reg_count;
    if (span == 0) span = 1;
    pick = $urandom_range(99);
    if (pick < 25) begin
      slot = SLOT_W'($urandom_range(DEPTH_DEF - 1));
      pick = $urandom_range(99);
      lo_t = (slot == 0) ? '0 : tab_time[slot - 1];
      hi_t = (slot == DEPTH_DEF - 1) ? '1 : tab_time[slot + 1];
      if (pick < 8) begin
        tm = '0;
      end else if (pick < 16) begin
        tm = $urandom;
      end else if (hi_t > lo_t && hi_t - lo_t > 1) begin
        tm = lo_t + 1 + ($urandom % (hi_t - lo_t - 1));
      end else begin
        tm = tab_time[slot];
      end
      write_entry(slot, tm, $urandom);
    end else begin
      s    = $urandom_range(span - 1);
      t    = tab_time[s];
      pick = $urandom_range(19);
      if (pick < 8)        q = t;
      else if (pick < 11)  q = t + 1;
      else if (pick < 14)  q = t - 1;
      else if (pick < 17)  q = $urandom_range(reg_oldest_time, reg_newest_time);
      else if (pick == 17) q = reg_oldest_time - 1;
      else if (pick == 18) q = reg_newest_time + 1;
      else                 q = $urandom_range(1) ? '1 : '0;
      query_at(q);
    end
  endtask

  task automatic test_directed_lookups();
    // empty index straight after reset
    query_at('0);
    query_at('1);
    set_window(9'd8, 32'd50, 32'd1000, 32'd1000, '1, 32'd7);
    write_entry(8'd0, 32'd100, '1);
    write_entry(8'd1, 32'd200, '0);
    write_entry(8'd2, 32'd300, 32'h1234_5678);
    write_entry(8'd3, '0, 32'hDEAD_BEEF);
    write_entry(8'd4, 32'd500, 32'h0000_0004);
    write_entry(8'd5, 32'd600, 32'h8000_0000);
    write_entry(8'd6, 32'd700, 32'h0000_0006);
    write_entry(8'd7, '1, 32'h0000_0007);
    query_at('0);
    query_at(32'd49);
    query_at(32'd50);
    query_at(32'd100);
    query_at(32'd250);
    query_at(32'd1000);
    query_at(32'd1001);
    query_at('1);
  endtask

  task automatic test_boundary_registers();
    drain_results();
    write_reg(CFG_RECS_PER_BLK, '0);
    write_reg(CFG_OLDEST_RECORD, '1);
    // writes to unmapped indexes must change nothing
    write_reg(CFG_UNMAPPED_6, '0);
    write_reg(CFG_UNMAPPED_7, '1);
    query_at('0);
    query_at('1);
    drain_results();
    write_reg(CFG_RECS_PER_BLK, '1);
    write_reg(CFG_NEWEST_RECORD, '1);
    query_at('1);
    query_at(32'd10);
  endtask

  // Sorted timestamps over every slot, a few left unused
  task automatic test_table_fill();
    word_t tm;
    int    s;
    tm = $urandom_range(1000, 1);
    for (s = 0; s < DEPTH_DEF; s++) begin
      if ($urandom_range(99) < 3) begin
        write_entry(SLOT_W'(s), '0, $urandom);
      end else begin
        tm = tm + $urandom_range(1 << 23, 1);
        write_entry(SLOT_W'(s), tm, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic(input int n, input logic [COUNT_W-1:0] count);
    int    span, s;
    word_t lo_t, hi_t, old_t, new_t, per_blk;
    span = (count > DEPTH_DEF) ? DEPTH_DEF : count;
    lo_t = '1;
    hi_t = '0;
    for (s = 0; s < span; s++) begin
      if (tab_time[s] != 0) begin
        if (tab_time[s] < lo_t) lo_t = tab_time[s];
        if (tab_time[s] > hi_t) hi_t = tab_time[s];
      end
    end
    if ($urandom_range(3) == 0) begin
      old_t = $urandom;
      new_t = $urandom;
    end else begin
      old_t = lo_t;
      new_t = hi_t;
    end
    case ($urandom_range(3))
      0:       per_blk = 1;
      1:       per_blk = $urandom_range(64, 2);
      2:       per_blk = $urandom_range(100000, 65);
      default: per_blk = $urandom;
    endcase
    set_window(count, old_t, new_t, $urandom, $urandom, per_blk);
    repeat (n) random_item();
  endtask

  task automatic test_backpressure();
    hold_token <= hold_token + 1;
    repeat (24) random_item();
    drain_results();
    repeat (24) random_item();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reg_count        = '0;
    reg_oldest_time  = '0;
    reg_newest_time  = '0;
    reg_oldest_rec   = '0;
    reg_newest_rec   = '0;
    reg_recs_per_blk = 32'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(14, 82);
    test_directed_lookups();
    test_boundary_registers();
    test_table_fill();
    test_random_traffic(200, 9'd256);

    set_idling(82, 14);
    test_random_traffic(150, 9'd511);
    test_random_traffic(60, 9'd1);

    set_idling(0, 0);
    test_random_traffic(150, COUNT_W'($urandom_range(256, 2)));
    test_backpressure();
    test_random_traffic(100, COUNT_W'($urandom_range(510, 257)));

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
